@@ hdl/preemptive_priority_scheduler_macros.svh @@
// Assertion macros shared by the scheduler RTL
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define PPS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, disabled during reset
`define PPS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`else

`define PPS_ASSERT_IMP(label, clk, rstn, ante, cons)

`define PPS_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ hdl/pps_pkg.sv @@
// Shared types and constants of the preemptive priority scheduler
package pps_pkg;

    localparam int SLOTS  = 16;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int TIME_W = 24;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(SLOTS);

    // Action codes of an input beat
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Status codes of a result beat
    localparam logic [2:0] STS_ADDED    = 3'd0;
    localparam logic [2:0] STS_REJECTED = 3'd1;
    localparam logic [2:0] STS_RAN      = 3'd2;
    localparam logic [2:0] STS_IDLE     = 3'd3;
    localparam logic [2:0] STS_CLEARED  = 3'd4;

    typedef struct packed {
        logic [7:0]  job_id;
        logic [15:0] arrival;
        logic [7:0]  prio;
        logic [15:0] remaining;
        logic [15:0] burst;
    } slot_t;

endpackage

@@ hdl/pps_slot_ram.sv @@
// Job table memory: one write port, one registered read port
module pps_slot_ram (
    input  logic                  clk,
    input  logic                  we,
    input  logic [pps_pkg::IDX_W-1:0] waddr,
    input  pps_pkg::slot_t        wdata,
    input  logic [pps_pkg::IDX_W-1:0] raddr,
    output pps_pkg::slot_t        rdata
);
    import pps_pkg::*;

    slot_t mem [SLOTS];
    slot_t rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/pps_cmp.sv @@
// Shared compare unit: does the candidate slot beat the best one so far
module pps_cmp (
    input  pps_pkg::slot_t             cand,
    input  pps_pkg::slot_t             best,
    input  logic                       best_found,
    input  logic [pps_pkg::TIME_W-1:0] now,
    output logic                       take
);
    import pps_pkg::*;

    logic eligible;
    logic better;

    always_comb begin
        eligible = (cand.remaining != 16'd0) && ({8'd0, cand.arrival} <= now);
        // Full tie keeps the earlier slot, which is the earlier add
        if (cand.prio != best.prio) begin
            better = cand.prio < best.prio;
        end else begin
            better = cand.arrival < best.arrival;
        end
        take = eligible && (!best_found || better);
    end

endmodule

@@ hdl/preemptive_priority_scheduler.sv @@
// Top level of the preemptive priority scheduler: sequencer, table and output register
// Add and clear beats: the result is staged, then put in the output register by the
// deliver state once that is free; the next beat is taken back in idle. Tick beats: a
// scan of the filled slots (read, compare, drain), then update and delivery likewise.
// A result may wait in the output register while the next beat runs; a second holds delivery.
// aresetn (synchronous, active low) empties the table and zeroes time; no clearing pass.
`include "preemptive_priority_scheduler_macros.svh"

module preemptive_priority_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_job_id,
    input  logic [15:0] s_arrival_tick,
    input  logic [15:0] s_burst_units,
    input  logic [7:0]  s_prio_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_ran_id,
    output logic        m_finished,
    output logic [23:0] m_tick_now,
    output logic [23:0] m_turnaround,
    output logic [23:0] m_waiting
);
    import pps_pkg::*;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_SCAN    = 4'b0010,
        ST_UPDATE  = 4'b0100,
        ST_DELIVER = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Fill count stands in for the valid bits: slots fill in order, only clear or reset empties them
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [TIME_W-1:0] fin_time_reg, fin_time_next;

    // Scan pipeline: issue index, then compare in the next cycle on the registered read data
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;

    // Best candidate so far
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    slot_t             best_reg, best_next;

    // Result under construction
    logic [2:0]        res_status_reg, res_status_next;
    logic [7:0]        res_ran_reg, res_ran_next;
    logic              res_fin_reg, res_fin_next;
    logic [TIME_W-1:0] res_now_reg, res_now_next;
    logic [TIME_W-1:0] res_tat_reg, res_tat_next;
    logic [15:0]       res_burst_reg, res_burst_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_status_reg, m_status_next;
    logic [7:0]        m_ran_reg, m_ran_next;
    logic              m_fin_reg, m_fin_next;
    logic [TIME_W-1:0] m_now_reg, m_now_next;
    logic [TIME_W-1:0] m_tat_reg, m_tat_next;
    logic [TIME_W-1:0] m_wt_reg, m_wt_next;

    // Table port signals
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    slot_t             ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    slot_t             ram_rdata;
    logic              cmp_take;

    logic              in_beat;
    logic              out_free;
    logic              scan_more;
    logic [TIME_W-1:0] wt_val;

    // Beat classes watched by the checks at the end
    logic              tick_beat;
    logic              full_add_beat;
    logic              full_held;

    pps_slot_ram u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pps_cmp u_cmp (
        .cand       (ram_rdata),
        .best       (best_reg),
        .best_found (found_reg),
        .now        (time_reg),
        .take       (cmp_take)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_beat   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign scan_more = (scan_idx_reg < cnt_reg);
    assign ram_raddr = scan_idx_reg[IDX_W-1:0];

    assign tick_beat     = in_beat && (s_action == ACT_TICK);
    assign full_add_beat = in_beat && (s_action == ACT_ADD) && (cnt_reg == SLOTS_CNT);
    assign full_held     = (res_status_reg == STS_REJECTED) && (cnt_reg == SLOTS_CNT);

    // Waiting floors at zero once time has saturated
    assign wt_val = (res_tat_reg > {8'd0, res_burst_reg})
                  ? (res_tat_reg - {8'd0, res_burst_reg}) : '0;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        time_next       = time_reg;
        fin_time_next   = fin_time_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = pend_reg;
        rd_idx_next     = rd_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        res_status_next = res_status_reg;
        res_ran_next    = res_ran_reg;
        res_fin_next    = res_fin_reg;
        res_now_next    = res_now_reg;
        res_tat_next    = res_tat_reg;
        res_burst_next  = res_burst_reg;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg[IDX_W-1:0];
        ram_wdata       = '{job_id: s_job_id, arrival: s_arrival_tick, prio: s_prio_level,
                            remaining: s_burst_units, burst: s_burst_units};

        // Drain the output register once the beat is taken
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_ran_next    = m_ran_reg;
        m_fin_next    = m_fin_reg;
        m_now_next    = m_now_reg;
        m_tat_next    = m_tat_reg;
        m_wt_next     = m_wt_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    res_ran_next   = '0;
                    res_fin_next   = 1'b0;
                    res_now_next   = '0;
                    res_tat_next   = '0;
                    res_burst_next = '0;
                    case (s_action)
                        ACT_ADD: begin
                            // Reject zero burst or full table, else store in next free slot
                            if (s_burst_units == 16'd0 || cnt_reg == SLOTS_CNT) begin
                                res_status_next = STS_REJECTED;
                            end else begin
                                ram_we          = 1'b1;
                                cnt_next        = cnt_reg + 1'b1;
                                res_status_next = STS_ADDED;
                            end
                            state_next = ST_DELIVER;
                        end
                        ACT_TICK: begin
                            // Precompute the saturated finish time for the update step
                            fin_time_next = (time_reg == TIME_MAX) ? time_reg
                                          : time_reg + 1'b1;
                            scan_idx_next = '0;
                            pend_next     = 1'b0;
                            found_next    = 1'b0;
                            state_next    = ST_SCAN;
                        end
                        ACT_CLEAR: begin
                            cnt_next        = '0;
                            time_next       = '0;
                            res_status_next = STS_CLEARED;
                            state_next      = ST_DELIVER;
                        end
                        default: begin
                            // Unused action: drop, no result
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Issue one read per filled slot
                if (scan_more) begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    rd_idx_next   = scan_idx_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                // Compare the slot read in the previous cycle
                if (pend_reg && cmp_take) begin
                    found_next    = 1'b1;
                    best_idx_next = rd_idx_reg;
                    best_next     = ram_rdata;
                end
                if (!scan_more && !pend_reg) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                time_next    = fin_time_reg;
                res_now_next = time_reg;
                if (found_reg) begin
                    ram_we              = 1'b1;
                    ram_waddr           = best_idx_reg;
                    ram_wdata           = best_reg;
                    ram_wdata.remaining = best_reg.remaining - 1'b1;
                    res_status_next     = STS_RAN;
                    res_ran_next        = best_reg.job_id;
                    if (best_reg.remaining == 16'd1) begin
                        res_fin_next   = 1'b1;
                        res_tat_next   = fin_time_reg - {8'd0, best_reg.arrival};
                        res_burst_next = best_reg.burst;
                    end
                end else begin
                    res_status_next = STS_IDLE;
                end
                state_next = ST_DELIVER;
            end
            ST_DELIVER: begin
                // Hold until the output register is free
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_ran_next    = res_ran_reg;
                    m_fin_next    = res_fin_reg;
                    m_now_next    = res_now_reg;
                    m_tat_next    = res_tat_reg;
                    m_wt_next     = wt_val;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            time_reg    <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            time_reg    <= time_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fin_time_reg   <= fin_time_next;
        scan_idx_reg   <= scan_idx_next;
        rd_idx_reg     <= rd_idx_next;
        best_idx_reg   <= best_idx_next;
        best_reg       <= best_next;
        res_status_reg <= res_status_next;
        res_ran_reg    <= res_ran_next;
        res_fin_reg    <= res_fin_next;
        res_now_reg    <= res_now_next;
        res_tat_reg    <= res_tat_next;
        res_burst_reg  <= res_burst_next;
        m_status_reg   <= m_status_next;
        m_ran_reg      <= m_ran_next;
        m_fin_reg      <= m_fin_next;
        m_now_reg      <= m_now_next;
        m_tat_reg      <= m_tat_next;
        m_wt_reg       <= m_wt_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_ran_id     = m_ran_reg;
    assign m_finished   = m_fin_reg;
    assign m_tick_now   = m_now_reg;
    assign m_turnaround = m_tat_reg;
    assign m_waiting    = m_wt_reg;

    // A tick beat always starts a table scan
    `PPS_ASSERT_NXT(a_tick_scans, aclk, aresetn, tick_beat, state_reg == ST_SCAN)

    // Time must not move while the table is being scanned
    `PPS_ASSERT_NXT(a_time_frozen, aclk, aresetn, state_reg == ST_SCAN, time_reg == $past(time_reg))

    // An add to a full table is rejected and leaves the fill count alone
    `PPS_ASSERT_NXT(a_full_reject, aclk, aresetn, full_add_beat, full_held)

    // A completed job is only ever reported on a run tick
    `PPS_ASSERT_IMP(a_fin_ran, aclk, aresetn, m_valid && m_finished, m_status == STS_RAN)

endmodule
